// File: design/khd_pkg.sv
// Shared types, constants and lookup functions for the keypad entry display.
// No dependencies; used by every other design file.
`default_nettype none

package khd_pkg;

    localparam int unsigned KEY_W      = 4;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned SAMPLE_W   = 5;
    localparam int unsigned DIGIT_W    = 3;
    localparam int unsigned DIGITS     = 8;
    localparam int unsigned MATRIX_W   = 16;
    localparam int unsigned SEG_W      = 8;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 24;
    localparam int unsigned DEF_HISTORY_SLOTS = 8;

    localparam logic [SEG_W-1:0]    SEG_OFF = 8'hFF;
    localparam logic [SAMPLE_W-1:0] NO_KEY  = 5'd16;

    typedef enum logic {
        KIND_SCAN    = 1'b0,
        KIND_REFRESH = 1'b1
    } kind_t;

    // Control broadcast to every history cell.
    typedef struct packed {
        logic             append;
        logic             full;
        logic [CNT_W-1:0] count;
        logic [KEY_W-1:0] key;
    } cell_ctrl_t;

    // Common-anode pattern for one hex digit (a low bit lights the segment).
    function automatic logic [SEG_W-1:0] seg_of_hex(input logic [KEY_W-1:0] v);
        logic [SEG_W-1:0] s;
        begin
            case (v)
                4'h0: s = 8'hC0;
                4'h1: s = 8'hF9;
                4'h2: s = 8'hA4;
                4'h3: s = 8'hB0;
                4'h4: s = 8'h99;
                4'h5: s = 8'h92;
                4'h6: s = 8'h82;
                4'h7: s = 8'hF8;
                4'h8: s = 8'h80;
                4'h9: s = 8'h90;
                4'hA: s = 8'h88;
                4'hB: s = 8'h83;
                4'hC: s = 8'hC6;
                4'hD: s = 8'hA1;
                4'hE: s = 8'h86;
                default: s = 8'h8E;
            endcase
            return s;
        end
    endfunction

    // Key value at matrix bit col*4+row; the keypad legend is row-major.
    function automatic logic [KEY_W-1:0] key_of_bit(input logic [3:0] b);
        logic [KEY_W-1:0] k;
        begin
            case (b)
                4'd0:  k = 4'h1;
                4'd1:  k = 4'h5;
                4'd2:  k = 4'h9;
                4'd3:  k = 4'hC;
                4'd4:  k = 4'h2;
                4'd5:  k = 4'h6;
                4'd6:  k = 4'h0;
                4'd7:  k = 4'hD;
                4'd8:  k = 4'h3;
                4'd9:  k = 4'h7;
                4'd10: k = 4'hA;
                4'd11: k = 4'hE;
                4'd12: k = 4'h4;
                4'd13: k = 4'h8;
                4'd14: k = 4'hB;
                default: k = 4'hF;
            endcase
            return k;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/khd_keyscan.sv
// Priority encoder that finds the first pressed key of a matrix sample.
// Depends on khd_pkg for widths and the key legend.
`default_nettype none

module khd_keyscan (
    input  wire logic [khd_pkg::MATRIX_W-1:0] matrix,
    output logic                              found,
    output logic [khd_pkg::KEY_W-1:0]         key
);
    import khd_pkg::*;

    // Scanning from the top bit down leaves the lowest pressed bit as winner,
    // which is the column-outer, row-inner scan order.
    always_comb begin
        found = 1'b0;
        key   = '0;
        for (int b = MATRIX_W - 1; b >= 0; b--) begin
            if (!matrix[b]) begin
                found = 1'b1;
                key   = key_of_bit(4'(b));
            end
        end
    end

endmodule

`default_nettype wire

// File: design/khd_cell.sv
// One history slot: holds a key, loads a new key on append, or takes its
// upper neighbor's key when a full history shifts. Depends on khd_pkg.
`default_nettype none

module khd_cell #(
    parameter int unsigned INDEX = 0
) (
    input  wire logic                       aclk,
    input  wire khd_pkg::cell_ctrl_t        ctrl,
    input  wire logic [khd_pkg::KEY_W-1:0]  neighbor_key,
    output logic [khd_pkg::KEY_W-1:0]       key_q
);
    import khd_pkg::*;

    localparam logic [CNT_W-1:0] INDEX_CODE = CNT_W'(INDEX);

    logic [KEY_W-1:0] key_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.append) begin
            if (ctrl.full) begin
                key_reg <= neighbor_key;
            end else if (ctrl.count == INDEX_CODE) begin
                key_reg <= ctrl.key;
            end
        end
    end

    assign key_q = key_reg;

endmodule

`default_nettype wire

// File: design/keypad_entry_display_top.sv
// Keypad scanner with a history of entered keys shown on eight digits.
// The result beat is registered and valid in the cycle after its input beat is taken.
// Throughput: one beat per cycle while m_axis_tready stays high; the output register frees when m_axis_tready is high.
// Reset (aresetn low, synchronous) empties the history, clears the last sample
// to no key and the digit pointer to zero; history slots themselves are not cleared.
// Depends on khd_pkg, khd_keyscan and khd_cell.
`default_nettype none

module keypad_entry_display_top #(
    parameter int unsigned HISTORY_SLOTS = khd_pkg::DEF_HISTORY_SLOTS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [khd_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [15:0] key_matrix
    input  wire logic                              s_axis_tuser,  // [0] kind
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] digit_enable, [15:8] segments, [19:16] key_value, [23:20] keys_held
    output logic [khd_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                   m_axis_tuser   // [0] key_taken
);
    import khd_pkg::*;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(HISTORY_SLOTS);

    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [SAMPLE_W-1:0] last_reg,   last_next;
    logic [DIGIT_W-1:0]  digit_reg,  digit_next;
    logic                m_valid_reg;
    logic [SEG_W-1:0]    en_reg,  en_next;
    logic [SEG_W-1:0]    seg_reg, seg_next;
    logic                taken_reg, taken_next;
    logic [KEY_W-1:0]    kval_reg,  kval_next;
    logic [CNT_W-1:0]    held_reg;

    logic             s_accept;
    logic             is_refresh;
    logic             found;
    logic [KEY_W-1:0] scan_key;
    logic             new_key;
    logic             full;
    logic [DIGIT_W-1:0] slot;
    logic [KEY_W-1:0] slot_key;
    cell_ctrl_t       ctrl;
    logic [KEY_W-1:0] cell_key [HISTORY_SLOTS];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign is_refresh    = (kind_t'(s_axis_tuser) == KIND_REFRESH);

    khd_keyscan u_keyscan (
        .matrix (s_axis_tdata[MATRIX_W-1:0]),
        .found  (found),
        .key    (scan_key)
    );

    assign full    = (count_reg == FULL_COUNT);
    assign new_key = found && ({1'b0, scan_key} != last_reg);

    assign ctrl.append = s_accept && !is_refresh && new_key;
    assign ctrl.full   = full;
    assign ctrl.count  = count_reg;
    assign ctrl.key    = scan_key;

    // The top cell's neighbor is the incoming key, so a full shift drops slot 0.
    for (genvar i = 0; i < HISTORY_SLOTS; i++) begin : g_cell
        logic [KEY_W-1:0] upper;
        if (i == HISTORY_SLOTS - 1) begin : g_top
            assign upper = scan_key;
        end else begin : g_mid
            assign upper = cell_key[i + 1];
        end
        khd_cell #(.INDEX(i)) u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .neighbor_key (upper),
            .key_q        (cell_key[i])
        );
    end

    // Slot i shows on digit 7-i.
    assign slot = DIGIT_W'(DIGITS - 1) - digit_reg;

    always_comb begin
        slot_key = '0;
        for (int i = 0; i < HISTORY_SLOTS; i++) begin
            if (slot == DIGIT_W'(i)) begin
                slot_key = cell_key[i];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        last_next  = last_reg;
        digit_next = digit_reg;
        en_next    = '0;
        seg_next   = SEG_OFF;
        taken_next = 1'b0;
        kval_next  = '0;
        if (is_refresh) begin
            digit_next = digit_reg + DIGIT_W'(1);
            en_next    = SEG_W'(1) << digit_reg;
            if ({1'b0, slot} < count_reg) begin
                seg_next = seg_of_hex(slot_key);
            end
        end else begin
            last_next = found ? {1'b0, scan_key} : NO_KEY;
            if (new_key) begin
                taken_next = 1'b1;
                kval_next  = scan_key;
                if (!full) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            last_reg    <= NO_KEY;
            digit_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                count_reg   <= count_next;
                last_reg    <= last_next;
                digit_reg   <= digit_next;
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            en_reg    <= en_next;
            seg_reg   <= seg_next;
            taken_reg <= taken_next;
            kval_reg  <= kval_next;
            held_reg  <= count_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {held_reg, kval_reg, seg_reg, en_reg};
    assign m_axis_tuser  = taken_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("history count exceeds slot count");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.append |=> (count_reg == $past(count_reg) + CNT_W'(1)) ||
                        (count_reg == FULL_COUNT && $past(full)))
        else $error("history count did not advance on append");

    a_digit_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_refresh) |=> digit_reg == $past(digit_reg) + DIGIT_W'(1))
        else $error("refresh digit did not advance");

    a_scan_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (en_reg == '0 && seg_reg == SEG_OFF))
        else $error("scan result drives a digit");

    a_enable_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_refresh) |=> $onehot(en_reg))
        else $error("refresh enable not one-hot");
`endif

endmodule

`default_nettype wire

// File: test/keypad_entry_display_checker.sv
// Scoreboard for the keypad entry display: tracks key history and digit pointer.
// Watches both stream channels and compares every result beat field by field.
// Depends on khd_pkg for the kind encoding and the blank and no-key codes.
`timescale 1ns / 100ps

module keypad_entry_display_checker #(
    parameter int unsigned HISTORY_SLOTS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] key_matrix
    input  wire logic        s_axis_tuser,   // [0] kind
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] digit_enable, [15:8] segments, [19:16] key_value, [23:20] keys_held
    input  wire logic [23:0] m_axis_tdata,
    input  wire logic        m_axis_tuser,   // [0] key_taken
    output int               mismatches,
    output int               awaited,
    output int               results_seen
);
    import khd_pkg::*;

    typedef struct packed {
        logic [7:0] digit_en;
        logic [7:0] seg;
        logic       taken;
        logic [3:0] key;
        logic [3:0] held;
    } display_beat_t;

    // Common-anode patterns, digit F in the top byte down to digit 0 in the lowest.
    localparam logic [127:0] HEX_SEGMENTS = {
        8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88, 8'h90, 8'h80,
        8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };

    logic [3:0] key_hist [8];
    logic [3:0] keys_held;
    logic [4:0] last_key;
    logic [2:0] digit_ptr;

    display_beat_t awaited_beats[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Columns are scanned outer and rows inner; a low bit means the key is down.
    function automatic logic [4:0] first_pressed(input logic [15:0] matrix);
        int idx;
        for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
                if (!matrix[col*4 + row]) begin
                    // Row-major legend runs 1..9, 0, A..F.
                    idx = row*4 + col;
                    if (idx < 9)
                        return 5'(idx + 1);
                    else if (idx == 9)
                        return 5'd0;
                    else
                        return 5'(idx);
                end
            end
        end
        return NO_KEY;
    endfunction

    function automatic display_beat_t step_keypad(input kind_t kind, input logic [15:0] matrix);
        display_beat_t r;
        logic [4:0] key;
        int slot;
        r = '0;
        r.seg = SEG_OFF;
        if (kind == KIND_SCAN) begin
            key = first_pressed(matrix);
            if (key != NO_KEY && key != last_key) begin
                if (keys_held < HISTORY_SLOTS) begin
                    key_hist[keys_held[2:0]] = key[3:0];
                    keys_held++;
                end else begin
                    // Full history: drop the oldest key and append at the top slot.
                    for (int i = 0; i < HISTORY_SLOTS - 1; i++)
                        key_hist[i] = key_hist[i + 1];
                    key_hist[HISTORY_SLOTS - 1] = key[3:0];
                end
                r.taken = 1'b1;
                r.key = key[3:0];
            end
            last_key = key;
        end else begin
            slot = 7 - int'(digit_ptr);
            r.digit_en = 8'b1 << digit_ptr;
            if (slot < int'(keys_held))
                r.seg = HEX_SEGMENTS[key_hist[slot]*8 +: 8];
            digit_ptr++;
        end
        r.held = keys_held;
        return r;
    endfunction

    always @(posedge aclk) begin
        display_beat_t got;
        display_beat_t want;
        if (!aresetn) begin
            keys_held = '0;
            last_key = NO_KEY;
            digit_ptr = '0;
            awaited_beats.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.digit_en = m_axis_tdata[7:0];
                got.seg = m_axis_tdata[15:8];
                got.key = m_axis_tdata[19:16];
                got.held = m_axis_tdata[23:20];
                got.taken = m_axis_tuser;
                results_seen++;
                if (awaited_beats.size() == 0) begin
                    report_mismatch("result beat with nothing awaited", m_axis_tdata, 0);
                end else begin
                    want = awaited_beats.pop_front();
                    if (got.digit_en !== want.digit_en)
                        report_mismatch("digit_enable", got.digit_en, want.digit_en);
                    if (got.seg !== want.seg)
                        report_mismatch("segments", got.seg, want.seg);
                    if (got.taken !== want.taken)
                        report_mismatch("key_taken", got.taken, want.taken);
                    if (got.key !== want.key)
                        report_mismatch("key_value", got.key, want.key);
                    if (got.held !== want.held)
                        report_mismatch("keys_held", got.held, want.held);
                end
            end
            // The result of this input beat cannot leave before the next edge.
            if (s_axis_tvalid && s_axis_tready)
                awaited_beats.push_back(step_keypad(kind_t'(s_axis_tuser), s_axis_tdata));
        end
        awaited = awaited_beats.size();
    end

endmodule

// File: test/keypad_entry_display_top_test.sv
// Stimulus and verdict for the keypad entry display block.
// Depends on khd_pkg, keypad_entry_display_top and keypad_entry_display_checker.
`timescale 1ns / 100ps

module keypad_entry_display_top_test;
    import khd_pkg::*;

    localparam int RANDOM_BEATS = 1325;
    localparam int CALM_BEATS   = 150;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'hFFFF;   // [15:0] key_matrix
    logic        s_axis_tuser = 1'b0;       // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] digit_enable, [15:8] segments, [19:16] key_value, [23:20] keys_held
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;              // [0] key_taken

    int   mismatches;
    int   awaited;
    int   results_seen;
    int   scan_beats;
    int   refresh_beats;
    int   stall_left;
    logic calm_tail = 1'b0;

    always #6 aclk = ~aclk;

    keypad_entry_display_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    keypad_entry_display_checker display_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .awaited       (awaited),
        .results_seen  (results_seen)
    );

    // Receiver back-pressure: random stalls of random length, none in the calm tail.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_beat(input kind_t kind, input logic [15:0] matrix);
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= matrix;
        s_axis_tuser <= kind;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        if (kind == KIND_SCAN)
            scan_beats++;
        else
            refresh_beats++;
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 16'($urandom());
        s_axis_tuser <= 1'($urandom());
        repeat (cycles - 1)
            @(negedge aclk);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (awaited != 0)
            @(negedge aclk);
    endtask

    // Mostly one chosen key with everything earlier in scan order released,
    // plus releases, repeats of the last sample and fully random matrices.
    function automatic logic [15:0] random_matrix(input logic [15:0] prev);
        logic [15:0] m;
        int b;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'hFFFF;
        if (pick == 1)
            return 16'($urandom());
        if (pick == 2)
            return prev;
        b = $urandom_range(0, 15);
        m = 16'($urandom()) | ((16'h1 << b) - 16'h1);
        m[b] = 1'b0;
        return m;
    endfunction

    initial begin
        logic [15:0] prev_matrix;
        logic [15:0] matrix;
        repeat (10)
            @(negedge aclk);
        aresetn <= 1'b1;

        // Empty history, release, all keys down, held key, then a key sweep
        // that fills the history and pushes the oldest entries out.
        send_beat(KIND_REFRESH, 16'h0000);
        send_beat(KIND_SCAN, 16'hFFFF);
        send_beat(KIND_SCAN, 16'h0000);
        send_beat(KIND_SCAN, 16'h0000);
        send_beat(KIND_SCAN, 16'hFFFF);
        for (int b = 1; b <= 12; b++)
            send_beat(KIND_SCAN, ~(16'h1 << b));
        repeat (8)
            send_beat(KIND_REFRESH, 16'hFFFF);
        drain_results();

        prev_matrix = 16'hFFFF;
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if (i == RANDOM_BEATS / 2)
                drain_results();
            if (i == RANDOM_BEATS - CALM_BEATS)
                calm_tail = 1'b1;
            if (!calm_tail && $urandom_range(0, 7) == 0)
                idle_sender($urandom_range(1, 15));
            if ($urandom_range(0, 9) < 4) begin
                send_beat(KIND_REFRESH, 16'($urandom()));
            end else begin
                matrix = random_matrix(prev_matrix);
                send_beat(KIND_SCAN, matrix);
                prev_matrix = matrix;
            end
        end

        drain_results();
        repeat (4)
            @(posedge aclk);
        $display("Sent %0d scan and %0d refresh beats; %0d result beats checked.",
                 scan_beats, refresh_beats, results_seen);
        $display("History filled, wrapped and redrawn under random stalls on both sides.");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d result beats still awaited.", awaited);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
